@@ design/jgdc_pkg.sv @@
package jgdc_pkg;

    // Last representable year; advancing past its final day is refused.
    localparam logic [15:0] YEAR_MAX = 16'd65535;

    localparam logic        MODE_LOAD    = 1'b0;
    localparam logic        MODE_ADVANCE = 1'b1;

    localparam logic [15:0] REFORM_YEAR            = 16'd1582;
    localparam logic [3:0]  REFORM_MONTH           = 4'd10;
    localparam logic [4:0]  REFORM_LAST_JULIAN_DAY = 5'd4;
    localparam logic [4:0]  REFORM_SKIP            = 5'd11;
    localparam logic [4:0]  REFORM_FIRST_DAY       = REFORM_LAST_JULIAN_DAY + REFORM_SKIP;
    localparam logic [4:0]  REFORM_MONTH_LEN       = 5'd21;
    localparam logic [4:0]  FEB_LEAP_LEN           = 5'd29;

    localparam logic [15:0] RESET_YEAR    = 16'd1;
    localparam logic [3:0]  JANUARY       = 4'd1;
    localparam logic [3:0]  FEBRUARY      = 4'd2;
    localparam logic [3:0]  DECEMBER      = 4'd12;
    localparam logic [4:0]  FIRST_DAY     = 5'd1;
    localparam logic [2:0]  SUNDAY        = 3'd0;
    localparam logic [2:0]  SATURDAY      = 3'd6;

    // Divisibility by 25: y*inv(25) mod 2^16 <= floor(65535/25)
    localparam logic [15:0] INV25       = 16'h5C29;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    typedef struct packed {
        logic        mode;
        logic [15:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [2:0]  load_weekday;
    } item_t;

    typedef struct packed {
        logic [15:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [2:0]  cur_weekday;
        logic        leap_flag;
        logic [4:0]  month_length;
        logic        overflow_flag;
    } result_t;

    // Days in a month, ignoring the reform month.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd1:    len = 5'd31;
                4'd2:    len = leap ? FEB_LEAP_LEN : 5'd28;
                4'd3:    len = 5'd31;
                4'd4:    len = 5'd30;
                4'd5:    len = 5'd31;
                4'd6:    len = 5'd30;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd31;
                4'd9:    len = 5'd30;
                4'd10:   len = 5'd31;
                4'd11:   len = 5'd30;
                4'd12:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Julian rule before the reform year, Gregorian from it on.
    // div100 = div4 & div25, div400 = div16 & div25.
    function automatic logic leap_rule(input logic [15:0] year, input logic div25);
        logic div4;
        logic div16;
        begin
            div4  = (year[1:0] == 2'd0);
            div16 = (year[3:0] == 4'd0);
            if (year < REFORM_YEAR)
                return div4;
            return (div4 && !div25) || (div16 && div25);
        end
    endfunction

endpackage

@@ design/julian_gregorian_date_counter.sv @@
// Calendar date counter (Julian before 1582, Gregorian from 1582, with the
// 1582-10-04 -> 1582-10-15 jump). Each accepted item either loads date and
// weekday (mode 0; year and month are clamped, a zero day becomes 1 and a
// weekday above 6 becomes Sunday) or advances one day (mode 1), and produces
// exactly one result describing the date now held. An item passes an input
// register, then one pass of next-day logic that updates the date state and
// the result register together. One item per cycle is sustained while the
// result side takes transfers; the leap test of the new year (one 16x16
// modular multiply and compare) is the longest path. After reset the date is
// 0001-01-01, Saturday. YEAR_MAX sets the last year: loads above it clamp to
// it, and advancing past its 31 December is refused with the overflow flag set.
module julian_gregorian_date_counter #(
    parameter logic [15:0] YEAR_MAX = jgdc_pkg::YEAR_MAX
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  jgdc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output jgdc_pkg::result_t result
);

    // Pipeline control
    logic              in_valid_reg;
    jgdc_pkg::item_t   in_reg;
    logic              out_valid_reg;
    jgdc_pkg::result_t out_reg;
    logic              advance;     // stage 2 may move on
    logic              take_in;

    // Date state; leap_reg tracks the leap status of year_reg
    logic [15:0] year_reg,    year_next;
    logic [3:0]  month_reg,   month_next;
    logic [4:0]  day_reg,     day_next;
    logic [2:0]  weekday_reg, weekday_next;
    logic        leap_reg,    leap_next;
    logic        overflow;

    logic [2:0]  weekday_inc;
    logic [4:0]  cur_len;
    logic [5:0]  day_inc;
    logic        reform_jump;
    logic [15:0] year_scaled;
    logic        div25;
    logic [4:0]  len_next;

    assign advance    = !out_valid_reg || !result_stall;
    assign take_in    = !in_valid_reg || advance;
    assign item_stall = !take_in;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take_in)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in && item_valid)
            in_reg <= item;
    end

    // Next-day logic
    assign weekday_inc = (weekday_reg == jgdc_pkg::SATURDAY) ? jgdc_pkg::SUNDAY
                                                               : weekday_reg + 3'd1;
    assign cur_len     = jgdc_pkg::month_days(month_reg, leap_reg);
    assign day_inc     = {1'b0, day_reg} + 6'd1;
    assign reform_jump = (year_reg == jgdc_pkg::REFORM_YEAR) &&
                         (month_reg == jgdc_pkg::REFORM_MONTH) &&
                         (day_reg == jgdc_pkg::REFORM_LAST_JULIAN_DAY);

    always_comb
    begin
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        weekday_next = weekday_reg;
        overflow     = 1'b0;
        if (in_reg.mode == jgdc_pkg::MODE_LOAD)
        begin
            // clamp loaded year and month into range; replace a zero day and a weekday above Saturday
            year_next    = (in_reg.load_year == 16'd0) ? 16'd1 : in_reg.load_year;
            if (year_next > YEAR_MAX)
                year_next = YEAR_MAX;
            month_next   = (in_reg.load_month == 4'd0) ? jgdc_pkg::JANUARY :
                           (in_reg.load_month > jgdc_pkg::DECEMBER) ? jgdc_pkg::DECEMBER :
                           in_reg.load_month;
            day_next     = (in_reg.load_day == 5'd0) ? jgdc_pkg::FIRST_DAY : in_reg.load_day;
            weekday_next = (in_reg.load_weekday > jgdc_pkg::SATURDAY) ? jgdc_pkg::SUNDAY
                                                                      : in_reg.load_weekday;
        end
        else if (reform_jump)
        begin
            day_next     = jgdc_pkg::REFORM_FIRST_DAY;
            weekday_next = weekday_inc;
        end
        else if (day_inc > {1'b0, cur_len})
        begin
            if (month_reg >= jgdc_pkg::DECEMBER)
            begin
                if (year_reg >= YEAR_MAX)
                    overflow = 1'b1;
                else
                begin
                    year_next    = year_reg + 16'd1;
                    month_next   = jgdc_pkg::JANUARY;
                    day_next     = jgdc_pkg::FIRST_DAY;
                    weekday_next = weekday_inc;
                end
            end
            else
            begin
                month_next   = month_reg + 4'd1;
                day_next     = jgdc_pkg::FIRST_DAY;
                weekday_next = weekday_inc;
            end
        end
        else
        begin
            day_next     = day_inc[4:0];
            weekday_next = weekday_inc;
        end
    end

    // Leap status of the new year; divisibility by 25 via modular inverse
    assign year_scaled = 16'(year_next * jgdc_pkg::INV25);
    assign div25       = (year_scaled <= jgdc_pkg::DIV25_LIMIT);
    assign leap_next   = jgdc_pkg::leap_rule(year_next, div25);
    assign len_next    = ((year_next == jgdc_pkg::REFORM_YEAR) &&
                          (month_next == jgdc_pkg::REFORM_MONTH)) ?
                         jgdc_pkg::REFORM_MONTH_LEN :
                         jgdc_pkg::month_days(month_next, leap_next);

    // State and result register update on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= jgdc_pkg::RESET_YEAR;
            month_reg     <= jgdc_pkg::JANUARY;
            day_reg       <= jgdc_pkg::FIRST_DAY;
            weekday_reg   <= jgdc_pkg::SATURDAY;
            leap_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                year_reg    <= year_next;
                month_reg   <= month_next;
                day_reg     <= day_next;
                weekday_reg <= weekday_next;
                leap_reg    <= leap_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg.cur_year      <= year_next;
            out_reg.cur_month     <= month_next;
            out_reg.cur_day       <= day_next;
            out_reg.cur_weekday   <= weekday_next;
            out_reg.leap_flag     <= leap_next;
            out_reg.month_length  <= len_next;
            out_reg.overflow_flag <= overflow;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // overflow only ever reported at the very last date
    a_overflow_at_top: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.overflow_flag) |->
            (result.cur_year == YEAR_MAX && result.cur_month == jgdc_pkg::DECEMBER))
        else $error("overflow reported below the last date");

    // held date fields always lie in range; the day is only checked to be nonzero
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg != 4'd0) && (month_reg <= jgdc_pkg::DECEMBER) &&
        (day_reg != 5'd0) && (weekday_reg <= jgdc_pkg::SATURDAY) && (year_reg != 16'd0))
        else $error("date state out of range");

    // a 29-day month is February of a leap year
    a_leap_feb: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.month_length == jgdc_pkg::FEB_LEAP_LEN) |->
            (result.leap_flag && result.cur_month == jgdc_pkg::FEBRUARY))
        else $error("29-day month outside leap February");

    // a processed item updates the result register and the state alike
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg) |=>
            (result.cur_year == year_reg && result.cur_day == day_reg &&
             result.leap_flag == leap_reg))
        else $error("result and date state disagree");
`endif

endmodule
